FILE: src/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

    localparam int KH_W      = 4;
    localparam int KW_W      = 4;
    localparam int IW_W      = 11;
    localparam int IH_W      = 13;
    localparam int BM_W      = 2;
    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int RAD_W     = 3;
    localparam int OFS_W     = 4;
    localparam int AREA_W    = 8;
    localparam int SUM_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_HEIGHT = 3'd0,
        REG_KERNEL_WIDTH  = 3'd1,
        REG_IMAGE_WIDTH   = 3'd2,
        REG_IMAGE_HEIGHT  = 3'd3,
        REG_BORDER_MODE   = 3'd4,
        REG_BORDER_VALUE  = 3'd5
    } t_cfg_reg;

    typedef enum logic [BM_W-1:0] {
        BORDER_REFLECT   = 2'd0,
        BORDER_REPLICATE = 2'd1,
        BORDER_CONSTANT  = 2'd2
    } t_border;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DIVGO,
        S_DIVW,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: src/bmf_div.sv
`default_nettype none
module bmf_div
    import bmf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_num,
    input  wire logic [AREA_W-1:0] i_den,
    output logic                   o_done,
    output logic [PIX_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(SUM_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [AREA_W:0]    r_rem;
    logic [SUM_W-1:0]   r_quo;
    logic [AREA_W:0]    shifted;
    logic               ge;

    assign shifted = {r_rem[AREA_W-1:0], r_quo[SUM_W-1]};
    assign ge      = shifted >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - {1'b0, i_den}) : shifted;
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[PIX_W-1:0];

endmodule
`default_nettype wire

FILE: src/box_mean_filter_unit.sv
`default_nettype none
// Box mean filter for an 8-bit grey frame streamed in raster order.
// The input channel (i_valid/o_ready) carries a pixel (i_cmd = 0) or a drain
// tick (i_cmd = 1); drain ticks after the last pixel flush the remaining
// outputs. The output channel (o_valid/i_ready) returns the rounded window
// mean together with row and frame end flags. Registers are written through
// the configuration channel, which is always ready; a geometry write restarts
// the frame. Outputs lag the inputs by radius_y*width+radius_x transfers.
// One item is handled at a time. A transfer that gives no result leaves the
// unit ready for the next item. A transfer that gives a result walks the
// window of (2*radius_y+1)*(2*radius_x+1) pixels through the single read
// port of the line store, one pixel per cycle, then a 16-step serial divider
// forms the mean and o_valid rises. The result is held in the output register
// until it is taken, and no input is taken meanwhile.
// After reset the registers hold their defaults (5x5, 640x480, reflect-101)
// and both counters are zero; the line store is not cleared.
module box_mean_filter_unit
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 15,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_cmd,
    input  wire logic [PIX_W-1:0]     i_pixel,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIX_W-1:0]          o_mean,
    output logic                      o_row_end,
    output logic                      o_frame_end,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int RING    = MAX_KERNEL + 1;
    localparam int RMAX    = (MAX_KERNEL - 1) / 2;
    localparam int DEPTH   = RING * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int SLW     = $clog2(RING);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int CNW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SW      = $clog2(DIM_MAX) + 2;

    t_state              r_state, n_state;
    logic [KH_W-1:0]     r_kh;
    logic [KW_W-1:0]     r_kw;
    logic [IW_W-1:0]     r_img_w;
    logic [IH_W-1:0]     r_img_h;
    logic [BM_W-1:0]     r_mode;
    logic [PIX_W-1:0]    r_bval;

    logic [CNW-1:0]      r_in_cnt, r_out_cnt;
    logic [XW-1:0]       r_in_col, r_ox;
    logic [SLW-1:0]      r_in_slot, r_oslot;
    logic [YW-1:0]       r_oy;
    logic signed [OFS_W-1:0] r_dx, r_dy;
    logic                r_rd_valid, r_rd_const;
    logic [PIX_W-1:0]    r_rd_data;
    logic [SUM_W-1:0]    r_sum;
    logic [PIX_W-1:0]    r_mean;
    logic [PIX_W-1:0]    r_line_store [DEPTH];

    logic [31:0]         w32, h32;
    logic [WW-1:0]       w;
    logic [HW-1:0]       h;
    logic [RAD_W-1:0]    ry, rx;
    logic signed [OFS_W-1:0] ry_s, rx_s;
    logic [AREA_W-1:0]   area;
    logic [CNW-1:0]      total, lag;
    logic                in_acc, out_acc, cfg_acc, geo_wr;
    logic                in_ok, pix_wr, produce, last_cell, frame_done;
    logic [CNW-1:0]      in_next;
    logic [AW-1:0]       waddr, raddr;
    logic signed [SW-1:0] oy_s, ox_s, ri, ci, rr, cc, dslot;
    logic [SW:0]         rmap, cmap;
    logic                cell_const;
    logic [SLW-1:0]      rslot;
    logic                div_start, div_done;
    logic [PIX_W-1:0]    div_quo;

    function automatic logic [SW:0] map_idx(input logic signed [SW-1:0] i,
                                            input logic signed [SW-1:0] n,
                                            input logic [BM_W-1:0] mode);
        logic signed [SW-1:0] t;
        logic                 c;
        c = 1'b0;
        t = i;
        if (i >= 0 && i < n) begin
            t = i;
        end else if (mode >= BORDER_CONSTANT) begin
            c = 1'b1;
        end else if (mode == BORDER_REPLICATE) begin
            t = (i < 0) ? '0 : n - 1;
        end else begin
            t = (i < 0) ? -i : ((n - 1) <<< 1) - i;
            if (t < 0) t = '0;
            if (t > n - 1) t = n - 1;
        end
        return {c, t};
    endfunction

    assign w32 = (r_img_w == '0) ? 32'd1 :
                 ((32'(r_img_w) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(r_img_w));
    assign h32 = (r_img_h == '0) ? 32'd1 :
                 ((32'(r_img_h) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(r_img_h));
    assign w   = w32[WW-1:0];
    assign h   = h32[HW-1:0];
    assign ry  = (32'(r_kh[KH_W-1:1]) > RMAX) ? RAD_W'(RMAX) : r_kh[KH_W-1:1];
    assign rx  = (32'(r_kw[KW_W-1:1]) > RMAX) ? RAD_W'(RMAX) : r_kw[KW_W-1:1];
    assign ry_s = $signed({1'b0, ry});
    assign rx_s = $signed({1'b0, rx});
    assign area = AREA_W'({ry, 1'b1}) * AREA_W'({rx, 1'b1});
    assign total = CNW'(w) * CNW'(h);
    assign lag   = CNW'(ry) * CNW'(w) + CNW'(rx);

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign geo_wr  = cfg_acc && (i_cfg_index == REG_KERNEL_HEIGHT ||
                     i_cfg_index == REG_KERNEL_WIDTH || i_cfg_index == REG_IMAGE_WIDTH ||
                     i_cfg_index == REG_IMAGE_HEIGHT);

    assign in_ok   = r_in_cnt < total;
    assign pix_wr  = in_acc && !i_cmd && in_ok;
    assign in_next = r_in_cnt + 1'b1;
    assign produce = (r_out_cnt < total) &&
                     (i_cmd ? !in_ok :
                      (in_ok && ({1'b0, in_next} > {1'b0, r_out_cnt} + {1'b0, lag})));
    assign last_cell  = (r_dx == rx_s) && (r_dy == ry_s);
    assign frame_done = ({1'b0, r_out_cnt} + 1'b1) >= {1'b0, total};

    assign oy_s = $signed(SW'(r_oy));
    assign ox_s = $signed(SW'(r_ox));
    assign ri   = oy_s + SW'(r_dy);
    assign ci   = ox_s + SW'(r_dx);
    assign rmap = map_idx(ri, $signed(SW'(h)), r_mode);
    assign cmap = map_idx(ci, $signed(SW'(w)), r_mode);
    assign rr   = rmap[SW-1:0];
    assign cc   = cmap[SW-1:0];
    assign cell_const = rmap[SW] || cmap[SW];

    always_comb begin
        dslot = $signed(SW'(r_oslot)) + (rr - oy_s);
        if (dslot < 0) begin
            dslot = dslot + SW'(RING);
        end else if (dslot >= SW'(RING)) begin
            dslot = dslot - SW'(RING);
        end
        rslot = dslot[SLW-1:0];
    end

    assign waddr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    assign raddr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(cc[XW-1:0]);

    always_ff @(posedge i_clk) begin
        if (pix_wr) begin
            r_line_store[waddr] <= i_pixel;
        end
        r_rd_data <= r_line_store[raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && produce) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (last_cell) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign div_start = (r_state == S_DIVGO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh       <= KH_W'(5);
            r_kw       <= KW_W'(5);
            r_img_w    <= IW_W'(640);
            r_img_h    <= IH_W'(480);
            r_mode     <= BORDER_REFLECT;
            r_bval     <= '0;
            r_in_cnt   <= '0;
            r_out_cnt  <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_oslot    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == S_SCAN);
            if (geo_wr) begin
                r_in_cnt  <= '0;
                r_out_cnt <= '0;
                r_in_col  <= '0;
                r_in_slot <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
                r_oslot   <= '0;
            end else begin
                if (pix_wr) begin
                    r_in_cnt <= in_next;
                    if (WW'(r_in_col) == w - 1'b1) begin
                        r_in_col  <= '0;
                        r_in_slot <= (32'(r_in_slot) == RING - 1) ? '0 : r_in_slot + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                if (out_acc) begin
                    if (frame_done) begin
                        r_out_cnt <= '0;
                        r_in_cnt  <= '0;
                        r_ox      <= '0;
                        r_oy      <= '0;
                        r_oslot   <= '0;
                        r_in_col  <= '0;
                        r_in_slot <= '0;
                    end else begin
                        r_out_cnt <= r_out_cnt + 1'b1;
                        if (WW'(r_ox) == w - 1'b1) begin
                            r_ox    <= '0;
                            r_oy    <= r_oy + 1'b1;
                            r_oslot <= (32'(r_oslot) == RING - 1) ? '0 : r_oslot + 1'b1;
                        end else begin
                            r_ox <= r_ox + 1'b1;
                        end
                    end
                end
            end
            if (cfg_acc) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_KERNEL_HEIGHT: r_kh    <= i_cfg_data[KH_W-1:0];
                    REG_KERNEL_WIDTH:  r_kw    <= i_cfg_data[KW_W-1:0];
                    REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[IW_W-1:0];
                    REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[IH_W-1:0];
                    REG_BORDER_MODE:   r_mode  <= i_cfg_data[BM_W-1:0];
                    REG_BORDER_VALUE:  r_bval  <= i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_dx  <= -rx_s;
            r_dy  <= -ry_s;
            r_sum <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                if (r_dy == ry_s) begin
                    r_dy <= -ry_s;
                    r_dx <= r_dx + 1'b1;
                end else begin
                    r_dy <= r_dy + 1'b1;
                end
            end
            if (r_rd_valid) begin
                r_sum <= r_sum + SUM_W'(r_rd_const ? r_bval : r_rd_data);
            end
        end
        r_rd_const <= cell_const;
        if (r_state == S_DIVW && div_done) begin
            r_mean <= div_quo;
        end
    end

    bmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum + SUM_W'(area >> 1)),
        .i_den   (area),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_mean      = r_mean;
    assign o_row_end   = (WW'(r_ox) == w - 1'b1);
    assign o_frame_end = (r_out_cnt == total - 1'b1);

`ifndef NO_ASSERTIONS
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt <= r_in_cnt)
        else $error("Output count has overtaken input count.");
    a_out_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_out_cnt < total))
        else $error("Result offered beyond the end of the frame.");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVW))
        else $error("Divider finished while no result was awaited.");
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_dx <= rx_s && r_dy <= ry_s))
        else $error("Window scan ran past its radius.");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench
    import bmf_pkg::*;
();

    localparam int MAXW      = 1024;
    localparam int MAXH      = 4096;
    localparam int RING      = 16;
    localparam int RAD_MAX   = 7;
    localparam int LIMIT     = 20000;
    localparam int HOLD_LEN  = 3000;
    localparam int SETTLE    = 300;
    localparam int ITEMS     = 1350;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             row_end;
        logic             frame_end;
    } t_window_out;

    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] pixel;
        bit               typed;
        bit               has_res;
        t_window_out      res;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_cmd = 1'b0;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 i_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_mean;
    logic                 o_row_end;
    logic                 o_frame_end;
    logic                 o_cfg_ready;

    box_mean_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_mean      (o_mean),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [KH_W-1:0]  kern_h;
    logic [KW_W-1:0]  kern_w;
    logic [IW_W-1:0]  img_w;
    logic [IH_W-1:0]  img_h;
    logic [BM_W-1:0]  pad_mode;
    logic [PIX_W-1:0] pad_value;
    logic [PIX_W-1:0] row_ring [RING*MAXW];
    int unsigned      pix_in;
    int unsigned      mean_out;

    t_window_out mean_q[$];
    int          errors = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    function automatic void frame_dims(output int w, output int h, output int ry,
                                       output int rx);
        w  = (img_w == 0) ? 1 : ((img_w > MAXW) ? MAXW : int'(img_w));
        h  = (img_h == 0) ? 1 : ((img_h > MAXH) ? MAXH : int'(img_h));
        ry = (int'(kern_h >> 1) > RAD_MAX) ? RAD_MAX : int'(kern_h >> 1);
        rx = (int'(kern_w >> 1) > RAD_MAX) ? RAD_MAX : int'(kern_w >> 1);
    endfunction

    function automatic int fold(int i, int n);
        int j;
        if (i >= 0 && i < n) return i;
        if (pad_mode >= BORDER_CONSTANT) return -1;
        if (pad_mode == BORDER_REPLICATE) return (i < 0) ? 0 : n - 1;
        j = (i < 0) ? -i : 2 * (n - 1) - i;
        if (j < 0) j = 0;
        if (j > n - 1) j = n - 1;
        return j;
    endfunction

    function automatic bit predict_mean(input logic cmd, input logic [PIX_W-1:0] pix,
                                        output t_window_out r);
        int w, h, ry, rx, r_idx, c_idx, oy, ox;
        int unsigned total, lag, area, sum;
        frame_dims(w, h, ry, rx);
        total = w * h;
        lag   = ry * w + rx;
        area  = (2 * ry + 1) * (2 * rx + 1);
        sum   = 0;
        r     = '0;
        if (cmd == CMD_PIXEL) begin
            if (pix_in >= total) return 0;
            row_ring[((pix_in / w) % RING) * MAXW + pix_in % w] = pix;
            pix_in++;
            if (pix_in <= mean_out + lag) return 0;
        end else if (pix_in < total) begin
            return 0;
        end
        if (mean_out >= total) return 0;
        oy = mean_out / w;
        ox = mean_out % w;
        for (int dx = -rx; dx <= rx; dx++) begin
            c_idx = fold(ox + dx, w);
            for (int dy = -ry; dy <= ry; dy++) begin
                r_idx = fold(oy + dy, h);
                if (r_idx < 0 || c_idx < 0) sum += pad_value;
                else sum += row_ring[(r_idx % RING) * MAXW + c_idx];
            end
        end
        r.mean      = PIX_W'((sum + area / 2) / area);
        r.row_end   = (ox == w - 1);
        r.frame_end = (mean_out == total - 1);
        mean_out++;
        if (mean_out >= total) begin
            mean_out = 0;
            pix_in   = 0;
        end
        return 1;
    endfunction

    task automatic report(input string msg);
        $display("%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (mean_q.size() == 0) begin
                report($sformatf("unexpected result mean=%0d", o_mean));
            end else begin
                t_window_out e;
                e = mean_q.pop_front();
                if (o_mean !== e.mean)
                    report($sformatf("mean %0d, expected %0d", o_mean, e.mean));
                if (o_row_end !== e.row_end)
                    report($sformatf("row_end %0b, expected %0b", o_row_end, e.row_end));
                if (o_frame_end !== e.frame_end)
                    report($sformatf("frame_end %0b, expected %0b", o_frame_end,
                                     e.frame_end));
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT) begin
            $display("box_mean_filter_unit: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix,
                             input bit typed, input bit has_res,
                             input t_window_out res);
        t_window_out r;
        bit          got;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        got = predict_mean(cmd, pix, r);
        if (typed) begin
            if (has_res) mean_q.push_back(res);
        end else if (got) begin
            mean_q.push_back(r);
        end
        items_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value,
                             input logic [CFG_DAT_W-1:0] keep);
        logic [CFG_DAT_W-1:0] data;
        data = (CFG_DAT_W'($urandom) & ~keep) | (CFG_DAT_W'(value) & keep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_KERNEL_HEIGHT: kern_h = data[KH_W-1:0];
            REG_KERNEL_WIDTH:  kern_w = data[KW_W-1:0];
            REG_IMAGE_WIDTH:   img_w = data[IW_W-1:0];
            REG_IMAGE_HEIGHT:  img_h = data[IH_W-1:0];
            REG_BORDER_MODE:   pad_mode = data[BM_W-1:0];
            REG_BORDER_VALUE:  pad_value = data[PIX_W-1:0];
            default: ;
        endcase
        if (idx <= REG_IMAGE_HEIGHT) begin
            pix_in   = 0;
            mean_out = 0;
        end
    endtask

    task automatic set_geometry(input int kh, input int kw, input int w, input int h,
                                input int mode, input int val);
        if ($urandom_range(3) == 0) cfg_write(REG_SPARE_LO, $urandom, '0);
        cfg_write(REG_KERNEL_HEIGHT, kh, 13'h000F);
        cfg_write(REG_KERNEL_WIDTH, kw, 13'h000F);
        cfg_write(REG_IMAGE_WIDTH, w, 13'h07FF);
        cfg_write(REG_IMAGE_HEIGHT, h, 13'h1FFF);
        cfg_write(REG_BORDER_MODE, mode, 13'h0003);
        cfg_write(REG_BORDER_VALUE, val, 13'h00FF);
        if ($urandom_range(3) == 0) cfg_write(REG_SPARE_HI, $urandom, '0);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_frame(input bit partial);
        int          w, h, ry, rx, total, stop, style;
        logic [7:0]  pix;
        t_window_out none;
        none = '0;
        frame_dims(w, h, ry, rx);
        total = w * h;
        stop  = partial ? $urandom_range(total - 1, 0) : total;
        style = $urandom_range(4);
        for (int i = 0; i < stop; i++) begin
            case (style)
                0: pix = 8'hFF;
                1: pix = 8'h00;
                2: pix = $urandom_range(1) ? 8'hFF : 8'h00;
                default: pix = PIX_W'($urandom);
            endcase
            if ($urandom_range(19) == 0)
                send_item(CMD_DRAIN, PIX_W'($urandom), 0, 0, none);
            send_item(CMD_PIXEL, pix, 0, 0, none);
        end
        if (partial) return;
        if (pix_in != 0 && $urandom_range(2) == 0)
            send_item(CMD_PIXEL, PIX_W'($urandom), 0, 0, none);
        while (pix_in != 0) send_item(CMD_DRAIN, PIX_W'($urandom), 0, 0, none);
        if ($urandom_range(2) == 0) send_item(CMD_DRAIN, PIX_W'($urandom), 0, 0, none);
    endtask

    task automatic phase_for(input int n);
        case (n % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
        endcase
    endtask

    t_stim_row unit_rows [9] = '{
        '{CMD_PIXEL, 8'd0,   1, 1, '{8'd0,   1'b0, 1'b0}},
        '{CMD_PIXEL, 8'd255, 1, 1, '{8'd255, 1'b0, 1'b0}},
        '{CMD_DRAIN, 8'd17,  1, 0, '{8'd0,   1'b0, 1'b0}},
        '{CMD_PIXEL, 8'd128, 1, 1, '{8'd128, 1'b1, 1'b0}},
        '{CMD_PIXEL, 8'd1,   1, 1, '{8'd1,   1'b0, 1'b0}},
        '{CMD_PIXEL, 8'd254, 1, 1, '{8'd254, 1'b0, 1'b0}},
        '{CMD_PIXEL, 8'd85,  1, 1, '{8'd85,  1'b1, 1'b1}},
        '{CMD_DRAIN, 8'd170, 1, 0, '{8'd0,   1'b0, 1'b0}},
        '{CMD_PIXEL, 8'd170, 1, 1, '{8'd170, 1'b0, 1'b0}}
    };

    initial begin
        int          n;
        t_window_out none;
        none      = '0;
        kern_h    = 5;
        kern_w    = 5;
        img_w     = 640;
        img_h     = 480;
        pad_mode  = BORDER_REFLECT;
        pad_value = 0;
        pix_in    = 0;
        mean_out  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_geometry(1, 1, 3, 2, BORDER_REFLECT, 0);
        foreach (unit_rows[k])
            send_item(unit_rows[k].cmd, unit_rows[k].pixel, unit_rows[k].typed,
                      unit_rows[k].has_res, unit_rows[k].res);
        settle();

        set_geometry(15, 15, 2047, 8191, 3, 255);
        set_geometry(15, 15, 9, 9, BORDER_REFLECT, 0);
        run_frame(0);
        settle();
        set_geometry(0, 14, 5, 4, BORDER_REPLICATE, 255);
        run_frame(0);
        settle();
        set_geometry(15, 15, 1, 1, BORDER_REFLECT, 0);
        run_frame(0);
        settle();
        set_geometry(6, 3, 2, 2, 3, 255);
        run_frame(0);
        settle();
        set_geometry(1, 15, 0, 0, BORDER_CONSTANT, 77);
        run_frame(0);
        settle();
        set_geometry(1, 15, 64, 1, BORDER_REFLECT, 0);
        run_frame(0);
        settle();

        n = 0;
        while (items_sent < ITEMS) begin
            phase_for(n / 2);
            set_geometry($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(7),
                         $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(7),
                         $urandom_range(24, 1), $urandom_range(10, 1),
                         $urandom_range(3), $urandom_range(255));
            if (n == 5) hold_req = HOLD_LEN;
            run_frame($urandom_range(9) == 0);
            settle();
            n++;
        end

        settle();
        if (errors == 0)
            $display("box_mean_filter_unit: match");
        else
            $display("box_mean_filter_unit: mismatch");
        $finish;
    end

endmodule
